// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define RSCAC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rscac assertion failed");
`define RSCAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rscac assertion failed");
`else
`define RSCAC_ASSERT(lbl, clk, rst_n, prop)
`define RSCAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- design/rscac_pkg.sv -----
// ----------------------------------------------------------------------------
// rscac_pkg
// Shared types and constants of the same-class adjacency counter.
// ----------------------------------------------------------------------------
`default_nettype none

package rscac_pkg;

    localparam int CFG_LEN_W = 13;
    localparam int CFG_IDX_W = 1;
    localparam int OPCODE_W  = 2;
    localparam int CLASS_W   = 8;
    localparam int COUNT_W   = 32;
    localparam int MATCH_W   = 3;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINE_LENGTH  = 1'b0,
        REG_CONNECTIVITY = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic push;
        logic clear;
    } step_ctrl_t;

endpackage

`default_nettype wire

// ----- design/raster_same_class_adjacency_count.sv -----
// ----------------------------------------------------------------------------
// raster_same_class_adjacency_count: push and clear give no result; one beat per cycle
// unless a read waits behind an untaken result. A read is registered in s1, then on m_.
// Throughput is set by the line buffer prefetch and count read-modify-write with bypass.
// Reset (sync, active low) empties the raster at once; no clearing pass is run.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module raster_same_class_adjacency_count
    import rscac_pkg::*;
#(
    parameter int MAX_LINE   = 4096,
    parameter int CLASS_BITS = 8,
    parameter int COUNT_BITS = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_LEN_W-1:0] cfg_wdata,

    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [OPCODE_W-1:0]  s_opcode,
    input  wire logic [CLASS_W-1:0]   s_class_value,
    input  wire logic                 s_is_missing,

    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic      [CLASS_W-1:0]   m_class_value_res,
    output logic                      m_present,
    output logic      [COUNT_W-1:0]   m_pair_count
);

    localparam int LEN_W = $clog2(MAX_LINE + 1);
    localparam int CMP_W = (LEN_W > CFG_LEN_W) ? LEN_W : CFG_LEN_W;

    function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_LEN_W-1:0] raw);
        logic [CMP_W-1:0] wide;
        begin
            wide = CMP_W'(raw);
            if (wide == '0) begin
                return LEN_W'(1);
            end else if (wide > CMP_W'(MAX_LINE)) begin
                return LEN_W'(MAX_LINE);
            end
            return LEN_W'(wide);
        end
    endfunction

    logic [CFG_LEN_W-1:0] len_reg, len_next;
    logic                 conn_reg, conn_next;

    logic                s1_valid_reg, s1_valid_next;
    logic [OPCODE_W-1:0] s1_op_reg;
    logic [CLASS_W-1:0]  s1_class_reg;
    logic                s1_missing_reg;

    logic                m_valid_reg, m_valid_next;
    logic [CLASS_W-1:0]  m_class_reg;
    logic                m_present_reg;
    logic [COUNT_W-1:0]  m_count_reg;

    logic                  s1_read, s1_push, s1_clear;
    logic                  advance, accept;
    logic [CLASS_BITS-1:0] s1_cls, rd_cls;
    step_ctrl_t            line_ctrl, cnt_ctrl;
    logic [MATCH_W-1:0]    match_cnt;
    logic [COUNT_BITS-1:0] cur_count;
    logic                  cur_seen;

    always_comb begin
        len_next  = len_reg;
        conn_next = conn_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_LINE_LENGTH:  len_next  = cfg_wdata;
                REG_CONNECTIVITY: conn_next = cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign s1_read  = s1_op_reg == OP_READ;
    assign s1_push  = s1_op_reg == OP_PUSH;
    assign s1_clear = s1_op_reg == OP_CLEAR;
    assign s1_cls   = CLASS_BITS'(s1_class_reg);

    assign advance = s1_valid_reg && (!s1_read || !m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    assign s1_valid_next = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign rd_cls        = accept ? CLASS_BITS'(s_class_value) : s1_cls;

    assign line_ctrl.push  = advance && s1_push;
    assign line_ctrl.clear = advance && s1_clear;
    assign cnt_ctrl.push   = advance && s1_push && !s1_missing_reg;
    assign cnt_ctrl.clear  = advance && s1_clear;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance && s1_read) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg      <= CFG_LEN_W'(1);
            conn_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            len_reg      <= len_next;
            conn_reg     <= conn_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_op_reg      <= s_opcode;
            s1_class_reg   <= s_class_value;
            s1_missing_reg <= s_is_missing;
        end
        if (advance && s1_read) begin
            m_class_reg   <= s1_class_reg;
            m_present_reg <= cur_seen;
            m_count_reg   <= COUNT_W'(cur_count);
        end
    end

    rscac_line_buf #(
        .MAX_LINE   (MAX_LINE),
        .CLASS_BITS (CLASS_BITS)
    ) u_line_buf (
        .clk        (aclk),
        .rst_n      (aresetn),
        .ctrl       (line_ctrl),
        .cls        (s1_cls),
        .missing    (s1_missing_reg),
        .len        (eff_len(len_reg)),
        .len_next   (eff_len(len_next)),
        .eight_conn (conn_reg),
        .match_cnt  (match_cnt)
    );

    rscac_count_store #(
        .CLASS_BITS (CLASS_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_count_store (
        .clk       (aclk),
        .rst_n     (aresetn),
        .ctrl      (cnt_ctrl),
        .cls       (s1_cls),
        .match_cnt (match_cnt),
        .rd_cls    (rd_cls),
        .cur_count (cur_count),
        .cur_seen  (cur_seen)
    );

    assign m_valid           = m_valid_reg;
    assign m_class_value_res = m_class_reg;
    assign m_present         = m_present_reg;
    assign m_pair_count      = m_count_reg;

    `RSCAC_ASSERT(a_blocked_read_stalls, aclk, aresetn, (s1_valid_reg && s1_read && m_valid_reg && !m_ready) |-> !s_ready)

endmodule

`default_nettype wire

// ----- design/rscac_ram.sv -----
// ----------------------------------------------------------------------------
// rscac_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rscac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- design/rscac_line_buf.sv -----
// ----------------------------------------------------------------------------
// rscac_line_buf
// Line buffer with neighbor window; counts same-class neighbors of a cell.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rscac_line_buf
    import rscac_pkg::*;
#(
    parameter int MAX_LINE   = 4096,
    parameter int CLASS_BITS = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire step_ctrl_t                        ctrl,
    input  wire logic [CLASS_BITS-1:0]             cls,
    input  wire logic                              missing,
    input  wire logic [$clog2(MAX_LINE + 1)-1:0]   len,
    input  wire logic [$clog2(MAX_LINE + 1)-1:0]   len_next,
    input  wire logic                              eight_conn,
    output logic      [MATCH_W-1:0]                match_cnt
);

    localparam int ADDR_W = $clog2(MAX_LINE);
    localparam int LEN_W  = $clog2(MAX_LINE + 1);
    localparam int CELL_W = CLASS_BITS + 1;
    localparam logic [CELL_W-1:0] MISSING_CELL = {1'b1, {CLASS_BITS{1'b0}}};

    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic              first_reg, first_next;
    logic [CELL_W-1:0] prev_reg, prev_next;
    logic [CELL_W-1:0] left_reg, left_next;
    logic [LEN_W-1:0]  fill_reg, fill_next;
    logic              vld0_reg, vld0_next;
    logic              vld1_reg, vld1_next;
    logic              byp0_reg, byp0_next;
    logic              byp1_reg, byp1_next;
    logic [CELL_W-1:0] byp_data_reg;

    logic              wrap_in;
    logic [ADDR_W-1:0] pos_cur;
    logic              first_cur;
    logic [CELL_W-1:0] prev_cur;
    logic [CELL_W-1:0] cur_cell;
    logic [CELL_W-1:0] rd0, rd1;
    logic [CELL_W-1:0] up_cell, upr_cell;
    logic [LEN_W-1:0]  pos_inc;
    logic              has_left, has_right;
    logic              hit_left, hit_up, hit_diag_l, hit_diag_r;
    logic [ADDR_W-1:0] ra0, ra1;

    // position taken by this beat, after a line length change if any
    assign wrap_in   = LEN_W'(pos_reg) >= len;
    assign pos_cur   = wrap_in ? '0 : pos_reg;
    assign first_cur = first_reg && !wrap_in;
    assign prev_cur  = wrap_in ? MISSING_CELL : prev_reg;
    assign cur_cell  = missing ? MISSING_CELL : {1'b0, cls};

    assign up_cell  = byp0_reg ? byp_data_reg : (vld0_reg ? rd0 : MISSING_CELL);
    assign upr_cell = byp1_reg ? byp_data_reg : (vld1_reg ? rd1 : MISSING_CELL);

    assign pos_inc   = LEN_W'(pos_cur) + LEN_W'(1);
    assign has_left  = pos_cur != '0;
    assign has_right = pos_inc < len;

    assign hit_left   = !missing && has_left && (left_reg == cur_cell);
    assign hit_up     = !missing && !first_cur && (up_cell == cur_cell);
    assign hit_diag_l = !missing && !first_cur && eight_conn && has_left
                        && (prev_cur == cur_cell);
    assign hit_diag_r = !missing && !first_cur && eight_conn && has_right
                        && (upr_cell == cur_cell);

    assign match_cnt = MATCH_W'(hit_left) + MATCH_W'(hit_up)
                     + MATCH_W'(hit_diag_l) + MATCH_W'(hit_diag_r);

    always_comb begin
        pos_next   = pos_reg;
        first_next = first_reg;
        prev_next  = prev_reg;
        left_next  = left_reg;
        fill_next  = fill_reg;
        if (ctrl.clear) begin
            pos_next   = '0;
            first_next = 1'b1;
            prev_next  = MISSING_CELL;
            fill_next  = '0;
        end else if (ctrl.push) begin
            left_next = cur_cell;
            if (pos_inc >= len) begin
                pos_next   = '0;
                first_next = 1'b0;
                prev_next  = MISSING_CELL;
            end else begin
                pos_next   = ADDR_W'(pos_inc);
                first_next = first_cur;
                prev_next  = up_cell;
            end
            if (pos_inc > fill_reg) begin
                fill_next = pos_inc;
            end
        end
    end

    // prefetch the previous line at the next beat's position
    assign ra0       = (LEN_W'(pos_next) >= len_next) ? '0 : pos_next;
    assign ra1       = ra0 + ADDR_W'(1);
    assign vld0_next = LEN_W'(ra0) < fill_next;
    assign vld1_next = LEN_W'(ra1) < fill_next;
    assign byp0_next = ctrl.push && (pos_cur == ra0);
    assign byp1_next = ctrl.push && (pos_cur == ra1);

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            pos_reg   <= '0;
            first_reg <= 1'b1;
            prev_reg  <= MISSING_CELL;
            left_reg  <= MISSING_CELL;
            fill_reg  <= '0;
            vld0_reg  <= 1'b0;
            vld1_reg  <= 1'b0;
            byp0_reg  <= 1'b0;
            byp1_reg  <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            first_reg <= first_next;
            prev_reg  <= prev_next;
            left_reg  <= left_next;
            fill_reg  <= fill_next;
            vld0_reg  <= vld0_next;
            vld1_reg  <= vld1_next;
            byp0_reg  <= byp0_next;
            byp1_reg  <= byp1_next;
        end
    end

    always_ff @(posedge clk) begin
        byp_data_reg <= cur_cell;
    end

    rscac_ram #(
        .WIDTH (CELL_W),
        .DEPTH (MAX_LINE)
    ) u_ram_up (
        .clk   (clk),
        .we    (ctrl.push),
        .waddr (pos_cur),
        .wdata (cur_cell),
        .raddr (ra0),
        .rdata (rd0)
    );

    rscac_ram #(
        .WIDTH (CELL_W),
        .DEPTH (MAX_LINE)
    ) u_ram_upr (
        .clk   (clk),
        .we    (ctrl.push),
        .waddr (pos_cur),
        .wdata (cur_cell),
        .raddr (ra1),
        .rdata (rd1)
    );

    `RSCAC_ASSERT_NEXT(a_clear_rewinds, clk, rst_n, ctrl.clear, pos_reg == '0 && first_reg && fill_reg == '0)
    `RSCAC_ASSERT_NEXT(a_push_fills, clk, rst_n, ctrl.push && !ctrl.clear, fill_reg != '0)

endmodule

`default_nettype wire

// ----- design/rscac_count_store.sv -----
// ----------------------------------------------------------------------------
// rscac_count_store
// Per-class saturating pair counts and presence flags, read-modify-write.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rscac_count_store
    import rscac_pkg::*;
#(
    parameter int CLASS_BITS = 8,
    parameter int COUNT_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire step_ctrl_t            ctrl,
    input  wire logic [CLASS_BITS-1:0] cls,
    input  wire logic [MATCH_W-1:0]    match_cnt,
    input  wire logic [CLASS_BITS-1:0] rd_cls,
    output logic      [COUNT_BITS-1:0] cur_count,
    output logic                       cur_seen
);

    localparam int NUM_CLASSES = 2 ** CLASS_BITS;
    localparam int SUM_W       = COUNT_BITS + 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [NUM_CLASSES-1:0] seen_reg, seen_next;
    logic                   byp_reg, byp_next;
    logic [COUNT_BITS-1:0]  byp_data_reg;
    logic [COUNT_BITS-1:0]  rd_data;
    logic [SUM_W-1:0]       sum;
    logic [COUNT_BITS-1:0]  new_count;

    assign cur_seen  = seen_reg[cls];
    assign cur_count = cur_seen ? (byp_reg ? byp_data_reg : rd_data) : '0;

    assign sum       = {1'b0, cur_count} + SUM_W'({match_cnt, 1'b0});
    assign new_count = sum[COUNT_BITS] ? COUNT_MAX : sum[COUNT_BITS-1:0];

    always_comb begin
        seen_next = seen_reg;
        if (ctrl.clear) begin
            seen_next = '0;
        end else if (ctrl.push) begin
            seen_next[cls] = 1'b1;
        end
    end

    assign byp_next = ctrl.push && (cls == rd_cls);

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            seen_reg <= '0;
            byp_reg  <= 1'b0;
        end else begin
            seen_reg <= seen_next;
            byp_reg  <= byp_next;
        end
    end

    always_ff @(posedge clk) begin
        byp_data_reg <= new_count;
    end

    rscac_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_CLASSES)
    ) u_ram_count (
        .clk   (clk),
        .we    (ctrl.push),
        .waddr (cls),
        .wdata (new_count),
        .raddr (rd_cls),
        .rdata (rd_data)
    );

    `RSCAC_ASSERT_NEXT(a_clear_empties, clk, rst_n, ctrl.clear, $countones(seen_reg) == 0)
    `RSCAC_ASSERT_NEXT(a_update_marks_seen, clk, rst_n, ctrl.push && !ctrl.clear, $countones(seen_reg) != 0)

endmodule

`default_nettype wire

// ----- tb/raster_adjacency_checker.sv -----
// ----------------------------------------------------------------------------
// Same-class adjacency counter checker
// Watches the configuration port and both beat channels. It keeps its own
// line buffer and per-class counts, predicts the result of every read beat
// and compares each result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module raster_adjacency_checker
    import rscac_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_LEN_W-1:0] cfg_wdata,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [OPCODE_W-1:0]  s_opcode,
    input  logic [CLASS_W-1:0]   s_class_value,
    input  logic                 s_is_missing,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [CLASS_W-1:0]   m_class_value_res,
    input  logic                 m_present,
    input  logic [COUNT_W-1:0]   m_pair_count,
    output int                   fail_count,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LINE_DEPTH = 4096;
    localparam logic [8:0]  NO_CLASS   = 9'h100;

    typedef struct {
        logic [CLASS_W-1:0] class_value;
        logic               present;
        logic [COUNT_W-1:0] pair_count;
    } class_count_t;

    class_count_t       expected_reads[$];
    logic [8:0]         line_buf[LINE_DEPTH];
    logic [8:0]         displaced_cell;
    int                 line_pos;
    bit                 on_first_line;
    logic [COUNT_W-1:0] pair_counts[256];
    bit                 class_seen[256];
    logic [CFG_LEN_W-1:0] line_len_reg;
    bit                 eight_way;
    int                 fails = 0;
    int                 waiting = 0;

    assign fail_count = fails;
    assign pending    = waiting;

    function automatic int active_length();
        if (line_len_reg == 0) return 1;
        if (line_len_reg > LINE_DEPTH) return LINE_DEPTH;
        return int'(line_len_reg);
    endfunction

    task automatic clear_raster();
        for (int i = 0; i < LINE_DEPTH; i++) line_buf[i] = NO_CLASS;
        for (int i = 0; i < 256; i++) begin
            pair_counts[i] = '0;
            class_seen[i]  = 1'b0;
        end
        displaced_cell = NO_CLASS;
        line_pos       = 0;
        on_first_line  = 1'b1;
    endtask

    task automatic add_cell(input logic [CLASS_W-1:0] cls, input logic missing);
        int           len;
        int           pos;
        int           add;
        logic [8:0]   cur;
        logic [8:0]   old;
        logic [COUNT_W:0] sum;
        len = active_length();
        pos = line_pos;
        cur = missing ? NO_CLASS : {1'b0, cls};
        if (pos >= len) begin
            pos            = 0;
            on_first_line  = 1'b0;
            displaced_cell = NO_CLASS;
        end
        if (!missing) begin
            add = 0;
            if (pos > 0 && line_buf[pos-1] == cur) add += 2;
            if (!on_first_line) begin
                if (line_buf[pos] == cur) add += 2;
                if (eight_way) begin
                    if (pos > 0 && displaced_cell == cur) add += 2;
                    if (pos + 1 < len && line_buf[pos+1] == cur) add += 2;
                end
            end
            class_seen[cls] = 1'b1;
            sum = {1'b0, pair_counts[cls]} + (COUNT_W+1)'(add);
            pair_counts[cls] = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
        end
        old            = line_buf[pos];
        line_buf[pos]  = cur;
        displaced_cell = old;
        pos++;
        if (pos >= len) begin
            pos            = 0;
            on_first_line  = 1'b0;
            displaced_cell = NO_CLASS;
        end
        line_pos = pos;
    endtask

    always @(posedge aclk) begin
        class_count_t want;
        if (!aresetn) begin
            clear_raster();
            line_len_reg = 1;
            eight_way    = 1'b0;
            expected_reads.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_reads.size() == 0) begin
                    $error("result beat with no read waiting");
                    fails++;
                end else begin
                    want = expected_reads.pop_front();
                    if (m_class_value_res !== want.class_value) begin
                        $error("class_value_res: expected %0d, got %0d",
                               want.class_value, m_class_value_res);
                        fails++;
                    end
                    if (m_present !== want.present) begin
                        $error("present: expected %0d, got %0d", want.present, m_present);
                        fails++;
                    end
                    if (m_pair_count !== want.pair_count) begin
                        $error("pair_count: expected %0d, got %0d",
                               want.pair_count, m_pair_count);
                        fails++;
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_LINE_LENGTH:  line_len_reg = cfg_wdata;
                    REG_CONNECTIVITY: eight_way    = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                case (s_opcode)
                    OP_PUSH:  add_cell(s_class_value, s_is_missing);
                    OP_READ: begin
                        want.class_value = s_class_value;
                        want.present     = class_seen[s_class_value];
                        want.pair_count  = pair_counts[s_class_value];
                        expected_reads.insert(expected_reads.size(), want);
                    end
                    OP_CLEAR: clear_raster();
                    default: ;
                endcase
            end
        end
        waiting = expected_reads.size();
    end

endmodule

// ----- tb/raster_same_class_adjacency_count_test.sv -----
// ----------------------------------------------------------------------------
// Same-class adjacency counter testbench
// Drives a short directed raster and then randomized phases of cell pushes,
// reads and clears under several line lengths and both neighborhoods, with
// random gaps on both channels. Checking is done by the checker module.
// ----------------------------------------------------------------------------
module raster_same_class_adjacency_count_test;
    import rscac_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam int PHASES     = 8;
    localparam int PHASE_LEN  = 75;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_LEN_W-1:0] cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [OPCODE_W-1:0]  s_opcode = '0;
    logic [CLASS_W-1:0]   s_class_value = '0;
    logic                 s_is_missing = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [CLASS_W-1:0]   m_class_value_res;
    logic                 m_present;
    logic [COUNT_W-1:0]   m_pair_count;
    int                   fail_count;
    int                   pending;
    bit                   quiet = 1'b0;
    logic [CLASS_W-1:0]   palette[3];

    raster_same_class_adjacency_count dut (.*);

    raster_adjacency_checker adjacency_check (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #4ms;
        $display("raster_same_class_adjacency_count_test NOT OK");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (quiet || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    // result side stalls
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    end

    task automatic send_beat(input logic [OPCODE_W-1:0] op, input logic [CLASS_W-1:0] cls,
                             input logic missing);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_opcode      <= op;
        s_class_value <= cls;
        s_is_missing  <= missing;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_config(input logic [CFG_LEN_W-1:0] len, input logic eight);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= REG_LINE_LENGTH;
        cfg_wdata <= len;
        @(posedge aclk);
        cfg_index <= REG_CONNECTIVITY;
        cfg_wdata <= CFG_LEN_W'(eight);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CLASS_W-1:0] pick_class();
        if ($urandom_range(99) < 85) return palette[$urandom_range(2)];
        return CLASS_W'($urandom);
    endfunction

    task automatic run_phase(input int items, input logic [CFG_LEN_W-1:0] len,
                             input logic eight);
        int r;
        set_config(len, eight);
        foreach (palette[i]) palette[i] = CLASS_W'($urandom);
        for (int i = 0; i < items; i++) begin
            r = $urandom_range(99);
            if (r < 3)
                send_beat(OP_CLEAR, CLASS_W'($urandom), 1'($urandom));
            else if (r < 5)
                send_beat(OP_UNUSED, CLASS_W'($urandom), 1'($urandom));
            else if (r < 20)
                send_beat(OP_READ, pick_class(), 1'($urandom));
            else
                send_beat(OP_PUSH, pick_class(), $urandom_range(9) == 0);
        end
    endtask

    initial begin
        logic [CFG_LEN_W-1:0] len;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // 3x3 raster, eight neighbors, extreme classes, one missing cell
        set_config(3, 1'b1);
        send_beat(OP_PUSH, 8'hFF, 1'b0);
        send_beat(OP_PUSH, 8'hFF, 1'b0);
        send_beat(OP_PUSH, 8'h00, 1'b0);
        send_beat(OP_PUSH, 8'hFF, 1'b0);
        send_beat(OP_PUSH, 8'hFF, 1'b0);
        send_beat(OP_PUSH, 8'h00, 1'b0);
        send_beat(OP_PUSH, 8'h00, 1'b0);
        send_beat(OP_PUSH, 8'hFF, 1'b1);
        send_beat(OP_PUSH, 8'h00, 1'b0);
        send_beat(OP_READ, 8'hFF, 1'b0);
        send_beat(OP_READ, 8'h00, 1'b1);
        send_beat(OP_READ, 8'h5A, 1'b0);
        send_beat(OP_UNUSED, 8'hFF, 1'b0);
        send_beat(OP_CLEAR, 8'h00, 1'b0);
        send_beat(OP_READ, 8'hFF, 1'b0);

        // line shortened mid-line: next push opens a new line
        set_config(4, 1'b0);
        send_beat(OP_PUSH, 8'hAA, 1'b0);
        send_beat(OP_PUSH, 8'hAA, 1'b0);
        set_config(2, 1'b0);
        send_beat(OP_PUSH, 8'hAA, 1'b0);
        send_beat(OP_READ, 8'hAA, 1'b0);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: len = 1;
                1: len = 4096;
                2: len = 0;
                3: len = 8191;
                4: len = CFG_LEN_W'($urandom_range(2, 6));
                5: len = CFG_LEN_W'($urandom_range(2, 12));
                6: len = 3;
                default: len = CFG_LEN_W'($urandom_range(1, 8191));
            endcase
            quiet = (p == 5);
            run_phase(PHASE_LEN, len, 1'(p % 2));
        end
        quiet = 1'b0;

        drain();
        repeat (4) @(posedge aclk);
        if (fail_count == 0)
            $display("raster_same_class_adjacency_count_test OK");
        else
            $display("raster_same_class_adjacency_count_test NOT OK");
        $finish;
    end

endmodule

// ----- raster_same_class_adjacency_count.f -----
+incdir+design
design/rscac_pkg.sv
design/rscac_ram.sv
design/rscac_line_buf.sv
design/rscac_count_store.sv
design/raster_same_class_adjacency_count.sv
tb/raster_adjacency_checker.sv
tb/raster_same_class_adjacency_count_test.sv
